// ----- hw/rtl/impq_pkg.sv -----
// ----------------------------------------------------------------------------
// impq_pkg: shared types and constants of the indexed min priority queue
// Sizes, function codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package impq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VTX_W    = 8;
  localparam int unsigned RANK_W   = 8;
  localparam int unsigned FUNC_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET  = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_RANK,
    PTR_INC,
    PTR_DEC,
    PTR_OCC
  } ptr_op_e;

  typedef enum logic [1:0] {
    OCC_HOLD,
    OCC_INC,
    OCC_DEC
  } occ_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_DOWN,
    WR_UP,
    WR_NEW
  } wr_op_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_EMPTY,
    RES_DATA
  } res_op_e;

  typedef enum logic {
    RD_PTR,
    RD_PTR_M1
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    ptr_op_e ptr_op;
    logic    pos_load;
    occ_op_e occ_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_op_e  wr_op;
    res_op_e res_op;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  occ_zero;
    logic  occ_full;
    logic  rank_ge_occ;
    logic  ptr_lt_occ;
    logic  ptr_gt_pos;
    logic  vtx_match;
    logic  key_eq;
    logic  key_less;
    logic  out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/impq_dpath.sv -----
// ----------------------------------------------------------------------------
// impq_dpath: datapath of the indexed min priority queue
// Sorted cell memory, pointer, occupancy, request latch and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module impq_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire impq_pkg::cmd_t               cmd_i,
  output impq_pkg::sts_t                    sts_o,
  input  wire logic [impq_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [impq_pkg::VTX_W-1:0]   vertex_i,
  input  wire logic signed [impq_pkg::KEY_W-1:0] key_i,
  input  wire logic [impq_pkg::RANK_W-1:0]  rank_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic [impq_pkg::VTX_W-1:0]        out_vertex_o,
  output logic                              empty_res_o
);

  logic [impq_pkg::KEY_W-1:0] key_mem [impq_pkg::CAPACITY];
  logic [impq_pkg::VTX_W-1:0] vtx_mem [impq_pkg::CAPACITY];

  logic [impq_pkg::FUNC_W-1:0] func_q;
  logic [impq_pkg::VTX_W-1:0]  vtx_in_q;
  logic [impq_pkg::KEY_W-1:0]  key_in_q;
  logic [impq_pkg::RANK_W-1:0] rank_q;
  logic [impq_pkg::CNT_W-1:0]  ptr_q, ptr_d, pos_q, occ_q, occ_d, ptr_m1;
  logic [impq_pkg::KEY_W-1:0]  rd_key_q;
  logic [impq_pkg::VTX_W-1:0]  rd_vtx_q;
  logic [impq_pkg::VTX_W-1:0]  res_vtx_q;
  logic                        res_empty_q;
  logic                        out_valid_q;
  logic [impq_pkg::VTX_W-1:0]  out_vtx_q;
  logic                        out_empty_q;
  logic [impq_pkg::IDX_W-1:0]  raddr, waddr;
  logic [impq_pkg::KEY_W-1:0]  wkey;
  logic [impq_pkg::VTX_W-1:0]  wvtx;
  logic                        wen;

  assign ptr_m1 = ptr_q - impq_pkg::CNT_W'(1);

  always_comb begin
    unique case (cmd_i.ptr_op)
      impq_pkg::PTR_ZERO: ptr_d = '0;
      impq_pkg::PTR_RANK: ptr_d = impq_pkg::CNT_W'(rank_q);
      impq_pkg::PTR_INC:  ptr_d = ptr_q + impq_pkg::CNT_W'(1);
      impq_pkg::PTR_DEC:  ptr_d = ptr_m1;
      impq_pkg::PTR_OCC:  ptr_d = occ_q;
      default:            ptr_d = ptr_q;
    endcase
    unique case (cmd_i.occ_op)
      impq_pkg::OCC_INC: occ_d = occ_q + impq_pkg::CNT_W'(1);
      impq_pkg::OCC_DEC: occ_d = occ_q - impq_pkg::CNT_W'(1);
      default:           occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pos_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      occ_q <= occ_d;
      if (cmd_i.pos_load) begin
        pos_q <= ptr_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request latch, result hold and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= func_i;
      vtx_in_q <= vertex_i;
      key_in_q <= key_i;
      rank_q   <= rank_i;
    end
    unique case (cmd_i.res_op)
      impq_pkg::RES_EMPTY: begin
        res_vtx_q   <= '0;
        res_empty_q <= 1'b1;
      end
      impq_pkg::RES_DATA: begin
        res_vtx_q   <= rd_vtx_q;
        res_empty_q <= 1'b0;
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_vtx_q   <= res_vtx_q;
      out_empty_q <= res_empty_q;
    end
  end

  always_comb begin
    raddr = (cmd_i.rd_sel == impq_pkg::RD_PTR) ? ptr_q[impq_pkg::IDX_W-1:0]
                                               : ptr_m1[impq_pkg::IDX_W-1:0];
    wen   = 1'b1;
    waddr = ptr_q[impq_pkg::IDX_W-1:0];
    wkey  = rd_key_q;
    wvtx  = rd_vtx_q;
    unique case (cmd_i.wr_op)
      impq_pkg::WR_DOWN: waddr = ptr_m1[impq_pkg::IDX_W-1:0];
      impq_pkg::WR_UP:   ;
      impq_pkg::WR_NEW: begin
        wkey = key_in_q;
        wvtx = vtx_in_q;
      end
      default: wen = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[raddr];
      rd_vtx_q <= vtx_mem[raddr];
    end
    if (wen) begin
      key_mem[waddr] <= wkey;
      vtx_mem[waddr] <= wvtx;
    end
  end

  always_comb begin
    sts_o.func        = impq_pkg::func_e'(func_q);
    sts_o.occ_zero    = (occ_q == '0);
    sts_o.occ_full    = (occ_q == impq_pkg::CNT_W'(impq_pkg::CAPACITY));
    sts_o.rank_ge_occ = (impq_pkg::CNT_W'(rank_q) >= occ_q);
    sts_o.ptr_lt_occ  = (ptr_q < occ_q);
    sts_o.ptr_gt_pos  = (ptr_q > pos_q);
    sts_o.vtx_match   = (rd_vtx_q == vtx_in_q);
    sts_o.key_eq      = (rd_key_q == key_in_q);
    sts_o.key_less    = ($signed(rd_key_q) < $signed(key_in_q));
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vtx_q;
  assign empty_res_o  = out_empty_q;

endmodule

`default_nettype wire

// ----- hw/rtl/impq_ctrl.sv -----
// ----------------------------------------------------------------------------
// impq_ctrl: sequencer of the indexed min priority queue
// Walks search, delete, scan, shift and emit steps over the cell memory.
// ----------------------------------------------------------------------------
`default_nettype none

module impq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire impq_pkg::sts_t sts_i,
  output impq_pkg::cmd_t      cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_DECODE   = 14'b00000000000010,
    ST_SRCH_RD  = 14'b00000000000100,
    ST_SRCH_CHK = 14'b00000000001000,
    ST_DEL_RD   = 14'b00000000010000,
    ST_DEL_WR   = 14'b00000000100000,
    ST_INS      = 14'b00000001000000,
    ST_SCAN_RD  = 14'b00000010000000,
    ST_SCAN_CHK = 14'b00000100000000,
    ST_SH_RD    = 14'b00001000000000,
    ST_SH_WR    = 14'b00010000000000,
    ST_PUT      = 14'b00100000000000,
    ST_GET_CHK  = 14'b01000000000000,
    ST_EMIT     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{latch: 1'b0, ptr_op: impq_pkg::PTR_HOLD, pos_load: 1'b0,
                occ_op: impq_pkg::OCC_HOLD, rd_en: 1'b0, rd_sel: impq_pkg::RD_PTR,
                wr_op: impq_pkg::WR_NONE, res_op: impq_pkg::RES_HOLD, emit: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.func)
          impq_pkg::FUNC_SET: begin
            cmd_o.ptr_op = impq_pkg::PTR_ZERO;
            state_d      = ST_SRCH_RD;
          end
          impq_pkg::FUNC_POP: begin
            if (sts_i.occ_zero) begin
              cmd_o.res_op = impq_pkg::RES_EMPTY;
              state_d      = ST_EMIT;
            end else begin
              // point at the head cell, read it next cycle
              cmd_o.ptr_op = impq_pkg::PTR_ZERO;
              state_d      = ST_SRCH_CHK;
            end
          end
          impq_pkg::FUNC_PEEK: begin
            if (sts_i.rank_ge_occ) begin
              cmd_o.res_op = impq_pkg::RES_EMPTY;
              state_d      = ST_EMIT;
            end else begin
              cmd_o.ptr_op = impq_pkg::PTR_RANK;
              state_d      = ST_SRCH_CHK;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SRCH_RD: begin
        if (sts_i.ptr_lt_occ) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_SRCH_CHK;
        end else begin
          state_d = ST_INS;
        end
      end
      ST_SRCH_CHK: begin
        if (sts_i.func == impq_pkg::FUNC_PEEK || sts_i.func == impq_pkg::FUNC_POP) begin
          // pointer holds the rank or the head: issue the read, then report it
          cmd_o.rd_en = 1'b1;
          state_d     = ST_GET_CHK;
        end else if (sts_i.vtx_match) begin
          if (sts_i.key_eq) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.ptr_op = impq_pkg::PTR_INC;
            state_d      = ST_DEL_RD;
          end
        end else begin
          cmd_o.ptr_op = impq_pkg::PTR_INC;
          state_d      = ST_SRCH_RD;
        end
      end
      ST_GET_CHK: begin
        cmd_o.res_op = impq_pkg::RES_DATA;
        if (sts_i.func == impq_pkg::FUNC_POP) begin
          cmd_o.ptr_op = impq_pkg::PTR_INC;
          state_d      = ST_DEL_RD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DEL_RD: begin
        if (sts_i.ptr_lt_occ) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_DEL_WR;
        end else begin
          cmd_o.occ_op = impq_pkg::OCC_DEC;
          state_d      = (sts_i.func == impq_pkg::FUNC_SET) ? ST_INS : ST_EMIT;
        end
      end
      ST_DEL_WR: begin
        cmd_o.wr_op  = impq_pkg::WR_DOWN;
        cmd_o.ptr_op = impq_pkg::PTR_INC;
        state_d      = ST_DEL_RD;
      end
      ST_INS: begin
        if (sts_i.occ_full) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.ptr_op = impq_pkg::PTR_ZERO;
          state_d      = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.ptr_lt_occ) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_SCAN_CHK;
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.ptr_op   = impq_pkg::PTR_OCC;
          state_d        = ST_SH_RD;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.key_less) begin
          cmd_o.ptr_op = impq_pkg::PTR_INC;
          state_d      = ST_SCAN_RD;
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.ptr_op   = impq_pkg::PTR_OCC;
          state_d        = ST_SH_RD;
        end
      end
      ST_SH_RD: begin
        if (sts_i.ptr_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = impq_pkg::RD_PTR_M1;
          state_d      = ST_SH_WR;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_op  = impq_pkg::WR_UP;
        cmd_o.ptr_op = impq_pkg::PTR_DEC;
        state_d      = ST_SH_RD;
      end
      ST_PUT: begin
        cmd_o.wr_op  = impq_pkg::WR_NEW;
        cmd_o.occ_op = impq_pkg::OCC_INC;
        state_d      = ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_min_priority_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_priority_queue: min priority queue of vertices with set-key
// Sorted cell memory walked by a sequencer; each vertex held at most once.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  -----------------------------------
//  in       in_valid_i/in_stall_o   func_i, vertex_i, key_i, rank_i
//  out      out_valid_o/out_stall_i out_vertex_o, empty_res_o
//
// One request at a time; in_stall_o is high from acceptance until done.
// Read at rank reads one cell and emits it. Remove minimum reads the head,
// shifts every later cell down and emits it. Set key searches for the vertex,
// shifts cells down on delete, scans for the slot and shifts cells up on insert.
// The cell memory takes one read and one write a cycle, with a registered read.
// Reset empties the queue at once (occupancy goes to zero, no sweep).
// A stalled result is held in the output register; the next request is
// taken meanwhile and waits in its emit step only if it also has a result.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_priority_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [impq_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [impq_pkg::VTX_W-1:0]        vertex_i,
  input  wire logic signed [impq_pkg::KEY_W-1:0] key_i,
  input  wire logic [impq_pkg::RANK_W-1:0]       rank_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [impq_pkg::VTX_W-1:0]             out_vertex_o,
  output logic                                   empty_res_o
);

  impq_pkg::cmd_t cmd;
  impq_pkg::sts_t sts;

  // sequencer: decode, search, delete, scan, shift, emit
  impq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // cell memory, pointers and output register
  impq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .vertex_i     (vertex_i),
    .key_i        (key_i),
    .rank_i       (rank_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_vertex_o (out_vertex_o),
    .empty_res_o  (empty_res_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/impq_checker.sv -----
// ----------------------------------------------------------------------------
// impq_checker: port-level checks of the indexed min priority queue
// Watches handshakes and result encoding on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module impq_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [impq_pkg::VTX_W-1:0]  out_vertex_o,
  input wire logic                        empty_res_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_vertex_o) && $stable(empty_res_o))
    else $error("stalled result changed");

  // an accepted request keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken back to back");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> out_vertex_o == '0)
    else $error("empty result carries a vertex");

endmodule

bind indexed_min_priority_queue impq_checker u_impq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_vertex_o (out_vertex_o),
  .empty_res_o  (empty_res_o)
);

`default_nettype wire

// ----- dv/tb_indexed_min_priority_queue.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_min_priority_queue: self-checking bench of the vertex min queue
// Directed and random requests go through a queue-fed driver. A sorted-list
// predictor tracks queue contents and expects one result per remove or read.
// A monitor checks each result, and idling varies by phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_min_priority_queue;
  import impq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES   = 8 * CAPACITY + 64;

  typedef struct {
    func_e             func;
    logic [VTX_W-1:0]  vertex;
    logic signed [KEY_W-1:0] key;
    logic [RANK_W-1:0] rank;
    int                in_idle_pct;
    int                out_stall_pct;
    bit                wait_drain;
  } request_t;

  typedef struct {
    logic [VTX_W-1:0] vertex;
    logic             empty;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [VTX_W-1:0] vertex_i = '0;
  logic signed [KEY_W-1:0] key_i = '0;
  logic [RANK_W-1:0] rank_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VTX_W-1:0] out_vertex_o;
  logic empty_res_o;

  indexed_min_priority_queue dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  request_t pending_requests[$];
  request_t current_req;
  result_t  expected_results[$];

  // Queue contents in service order: ascending key, newest first among ties.
  logic signed [KEY_W-1:0] held_key[$];
  logic [VTX_W-1:0]        held_vertex[$];

  int in_idle_pct;
  int out_stall_pct;
  int mismatch_count;
  int idle_cycles;

  // Update the held list for one accepted request; queue any result it causes.
  task automatic apply_request(request_t r);
    int pos;
    int found;
    found = -1;
    case (r.func)
      FUNC_SET: begin
        foreach (held_vertex[i]) if (held_vertex[i] == r.vertex) found = i;
        if (found >= 0) begin
          // Same key: leave the vertex where it stands.
          if (held_key[found] == r.key) return;
          held_key.delete(found);
          held_vertex.delete(found);
        end
        // Full store: drop a new vertex.
        if (held_key.size() >= CAPACITY) return;
        pos = 0;
        while (pos < held_key.size() && held_key[pos] < r.key) pos++;
        held_key.insert(pos, r.key);
        held_vertex.insert(pos, r.vertex);
      end
      FUNC_POP: begin
        if (held_key.size() == 0) begin
          expected_results.push_back('{vertex: '0, empty: 1'b1});
        end else begin
          expected_results.push_back('{vertex: held_vertex[0], empty: 1'b0});
          held_key.delete(0);
          held_vertex.delete(0);
        end
      end
      FUNC_PEEK: begin
        if (r.rank >= held_key.size()) begin
          expected_results.push_back('{vertex: '0, empty: 1'b1});
        end else begin
          expected_results.push_back('{vertex: held_vertex[r.rank], empty: 1'b0});
        end
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_req(func_e f, int v, logic signed [KEY_W-1:0] k,
                                        int rk, int ip, int op);
    request_t r;
    r.func = f;
    r.vertex = v[VTX_W-1:0];
    r.key = k;
    r.rank = rk[RANK_W-1:0];
    r.in_idle_pct = ip;
    r.out_stall_pct = op;
    r.wait_drain = 1'b0;
    return r;
  endfunction

  // Random request: mostly a small vertex pool and narrow keys so that ties,
  // equal-key updates and moves happen often; full ranges now and then.
  function automatic request_t random_req(int ip, int op);
    int sel;
    int v;
    int rk;
    logic signed [KEY_W-1:0] k;
    sel = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15);
    case ($urandom_range(5))
      0: k = $urandom;
      1: k = ($urandom_range(1) == 0) ? 32'sh7fffffff : 32'sh80000000;
      default: k = $signed($urandom_range(8)) - 4;
    endcase
    rk = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(20);
    if (sel < 52) return make_req(FUNC_SET, v, k, rk, ip, op);
    if (sel < 75) return make_req(FUNC_POP, v, k, rk, ip, op);
    if (sel < 96) return make_req(FUNC_PEEK, v, k, rk, ip, op);
    return make_req(FUNC_NONE, v, k, rk, ip, op);
  endfunction

  // Fill the stimulus, then wait for the run to settle and judge it.
  initial begin
    request_t r;
    int ip[4];
    int op[4];
    ip = '{0, 68, 0, 10};
    op = '{0, 0, 68, 10};

    // Directed: empty cases, extremes, ties, equal-key update, move, unused code.
    pending_requests.push_back(make_req(FUNC_POP, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_PEEK, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 0, 32'sh7fffffff, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 255, 32'sh80000000, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 1, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 2, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 1, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 3, -1, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_SET, 3, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++) pending_requests.push_back(make_req(FUNC_PEEK, 0, 0, i, 0, 0));
    pending_requests.push_back(make_req(FUNC_PEEK, 0, 0, 255, 0, 0));
    pending_requests.push_back(make_req(FUNC_NONE, 170, 32'sh5555aaaa, 85, 0, 0));
    for (int i = 0; i < 6; i++) pending_requests.push_back(make_req(FUNC_POP, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(FUNC_PEEK, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 110; n++) begin
        r = random_req(ip[ph], op[ph]);
        // Hold off the sender once until every result is back.
        if (ph == 2 && n == 0) r.wait_drain = 1'b1;
        pending_requests.push_back(r);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("indexed_min_priority_queue: match");
    end else begin
      $display("indexed_min_priority_queue: mismatch");
    end
    $finish;
  end

  // Driver: on acceptance predict, then load the next request or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_request(current_req);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() > 0) begin
          in_idle_pct = pending_requests[0].in_idle_pct;
          out_stall_pct = pending_requests[0].out_stall_pct;
        end
        if (pending_requests.size() > 0
            && !(pending_requests[0].wait_drain && expected_results.size() > 0)
            && $urandom_range(99) >= in_idle_pct) begin
          current_req = pending_requests.pop_front();
          func_i <= current_req.func;
          vertex_i <= current_req.vertex;
          key_i <= current_req.key;
          rank_i <= current_req.rank;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: vertex %0d empty %0b", out_vertex_o, empty_res_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_vertex_o !== exp_res.vertex || empty_res_o !== exp_res.empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result differs: expected vertex %0d empty %0b, got vertex %0d empty %0b",
                     exp_res.vertex, exp_res.empty, out_vertex_o, empty_res_o);
        end
      end
    end
  end

  // Watchdog: stop a run that makes no progress on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("indexed_min_priority_queue: mismatch");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
